>>> rtl/core/bmprle8_pkg.sv
// ----------------------------------------------------------------------------
// bmprle8_pkg
// Shared types and constants for the RLE8 bitmap stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmprle8_pkg;

    // Field widths of the stream items
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 24;
    localparam int CFG_W     = 13;
    localparam int COLUMN_W  = 16;
    localparam int ROW_W     = 14;
    localparam int PHASE_W   = 3;

    // Packed widths of the channel buses
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Configuration register indexes
    localparam logic CFG_ROW_STRIDE = 1'b0;
    localparam logic CFG_ROW_COUNT  = 1'b1;

    // Decoder phase codes
    localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_VALUE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ESCAPE  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DX      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DY      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LITERAL = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PAD     = 3'd6;

    // Second byte of an escape pair
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    // One decoded result
    typedef struct packed {
        logic [BYTE_W-1:0] write_value;
        logic [BYTE_W-1:0] write_length;
        logic [ADDR_W-1:0] write_address;
    } result_data_t;

    typedef struct packed {
        logic decode_done;
        logic write_valid;
    } result_flags_t;

endpackage : bmprle8_pkg

`default_nettype wire

>>> rtl/core/bmp_rle8_decoder_top.sv
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_top
// RLE8 bitmap decoder: one coded byte in, one result out, which may carry a pixel write command.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_*       in         coded byte (tdata), clear-state flag (tuser)
//  m_*       out        address/length/value (tdata), write/done flags (tuser)
//  cfg_*     in         register index and 13-bit write data
//
//  One byte per cycle is accepted while s_tready is high; its result appears
//  in the output register on the next cycle. The single result register
//  holds the address multiply and add.
//  Reset (aresetn, synchronous, active low) returns the decode state and the
//  registers to their defaults and empties the output register.
//  A stall on m_tready holds the result; s_tready drops only while a result
//  is held and not taken. cfg_ready is always high.
//
`default_nettype none

module bmp_rle8_decoder_top #(
    parameter int ADDR_BITS  = 24,
    parameter int MAX_STRIDE = 4096,
    parameter int MAX_ROWS   = 4096
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // Coded byte stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [bmprle8_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] stream_byte
    input  wire  [bmprle8_pkg::S_TUSER_W-1:0] s_tuser,   // [0] first_byte
    // Pixel write commands
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [23:0] write_address, [31:24] write_length, [39:32] write_value
    output logic [bmprle8_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [bmprle8_pkg::M_TUSER_W-1:0] m_tuser,   // [0] write_valid, [1] decode_done
    // Configuration writes
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire                               cfg_index,
    input  wire  [bmprle8_pkg::CFG_W-1:0]     cfg_data
);

    import bmprle8_pkg::*;

    localparam int OUT_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int PROD_W   = ROW_W + CFG_W + 1;
    localparam logic [PROD_W-1:0] ADDR_MASK = PROD_W'((64'd1 << OUT_BITS) - 64'd1);
    localparam logic [16:0] STRIDE_LIMIT = 17'(MAX_STRIDE);
    localparam logic [16:0] ROWS_LIMIT   = 17'(MAX_ROWS);

    // Configuration registers
    logic [CFG_W-1:0] row_stride_reg;
    logic [CFG_W-1:0] row_count_reg;

    // Decode state
    logic [PHASE_W-1:0]  phase_reg,         phase_next;
    logic [BYTE_W-1:0]   held_count_reg,    held_count_next;
    logic [BYTE_W-1:0]   literals_left_reg, literals_left_next;
    logic                pad_pending_reg,   pad_pending_next;
    logic [COLUMN_W-1:0] column_reg,        column_next;
    logic [ROW_W-1:0]    row_index_reg,     row_index_next;
    logic                finished_reg,      finished_next;

    // Output register
    logic                m_valid_reg;
    result_data_t        m_data_reg,  m_data_next;
    result_flags_t       m_flags_reg, m_flags_next;

    // Working copies after an optional clear
    logic [PHASE_W-1:0]  cur_phase;
    logic [BYTE_W-1:0]   cur_held;
    logic [BYTE_W-1:0]   cur_literals;
    logic                cur_pad;
    logic [COLUMN_W-1:0] cur_column;
    logic [ROW_W-1:0]    cur_row;
    logic                cur_finished;
    logic                cur_done;

    logic [CFG_W-1:0]    eff_stride;
    logic [CFG_W-1:0]    eff_rows;
    logic [PROD_W-1:0]   full_address;
    logic [BYTE_W-1:0]   in_byte;
    logic                in_first;
    logic                s_accept;
    logic [BYTE_W-1:0]   literals_dec;

    assign in_byte   = s_tdata[BYTE_W-1:0];
    assign in_first  = s_tuser[0];
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flags_reg;

    // Clamp the registers to their supported maxima
    always_comb begin
        eff_stride = ({4'd0, row_stride_reg} > STRIDE_LIMIT) ? CFG_W'(MAX_STRIDE)
                                                             : row_stride_reg;
        eff_rows   = ({4'd0, row_count_reg} > ROWS_LIMIT) ? CFG_W'(MAX_ROWS)
                                                          : row_count_reg;
    end

    // Apply the clear flag ahead of the byte
    always_comb begin
        cur_phase    = in_first ? PH_COUNT : phase_reg;
        cur_held     = in_first ? '0 : held_count_reg;
        cur_literals = in_first ? '0 : literals_left_reg;
        cur_pad      = in_first ? 1'b0 : pad_pending_reg;
        cur_column   = in_first ? '0 : column_reg;
        cur_row      = in_first ? '0 : row_index_reg;
        cur_finished = in_first ? 1'b0 : finished_reg;
        cur_done     = cur_finished || (cur_row >= {1'b0, eff_rows});
    end

    // Destination address of the current position
    assign full_address = (PROD_W'(cur_row) * PROD_W'(eff_stride) + PROD_W'(cur_column))
                          & ADDR_MASK;
    assign literals_dec = cur_literals - 8'd1;

    // Advance the decode state and form the result
    always_comb begin
        phase_next         = cur_phase;
        held_count_next    = cur_held;
        literals_left_next = cur_literals;
        pad_pending_next   = cur_pad;
        column_next        = cur_column;
        row_index_next     = cur_row;
        finished_next      = cur_finished;
        m_data_next        = '0;
        m_flags_next       = '0;

        if (!cur_done) begin
            case (cur_phase)
                PH_VALUE: begin
                    m_flags_next.write_valid   = 1'b1;
                    m_data_next.write_address  = ADDR_W'(full_address);
                    m_data_next.write_length   = cur_held;
                    m_data_next.write_value    = in_byte;
                    column_next = cur_column + COLUMN_W'(cur_held);
                    phase_next  = PH_COUNT;
                end
                PH_ESCAPE: begin
                    if (in_byte == ESC_EOL) begin
                        row_index_next = cur_row + ROW_W'(1);
                        column_next    = '0;
                        phase_next     = PH_COUNT;
                    end else if (in_byte == ESC_EOB) begin
                        finished_next = 1'b1;
                        phase_next    = PH_COUNT;
                    end else if (in_byte == ESC_DELTA) begin
                        phase_next = PH_DX;
                    end else begin
                        literals_left_next = in_byte;
                        pad_pending_next   = in_byte[0];
                        phase_next         = PH_LITERAL;
                    end
                end
                PH_DX: begin
                    column_next = cur_column + COLUMN_W'(in_byte);
                    phase_next  = PH_DY;
                end
                PH_DY: begin
                    row_index_next = cur_row + ROW_W'(in_byte);
                    phase_next     = PH_COUNT;
                end
                PH_LITERAL: begin
                    m_flags_next.write_valid   = 1'b1;
                    m_data_next.write_address  = ADDR_W'(full_address);
                    m_data_next.write_length   = 8'd1;
                    m_data_next.write_value    = in_byte;
                    column_next        = cur_column + COLUMN_W'(1);
                    literals_left_next = literals_dec;
                    if (literals_dec == '0) begin
                        phase_next = cur_pad ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD: begin
                    // Padding byte is written but the column stays put
                    m_flags_next.write_valid   = 1'b1;
                    m_data_next.write_address  = ADDR_W'(full_address);
                    m_data_next.write_length   = 8'd1;
                    m_data_next.write_value    = in_byte;
                    pad_pending_next = 1'b0;
                    phase_next       = PH_COUNT;
                end
                default: begin
                    if (in_byte != '0) begin
                        held_count_next = in_byte;
                        phase_next      = PH_VALUE;
                    end else begin
                        phase_next = PH_ESCAPE;
                    end
                end
            endcase
        end

        m_flags_next.decode_done = finished_next || (row_index_next >= {1'b0, eff_rows});
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_stride_reg <= CFG_W'(1);
            row_count_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROW_STRIDE: row_stride_reg <= cfg_data;
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                default:        row_stride_reg <= row_stride_reg;
            endcase
        end
    end

    // Decode state: advance on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_COUNT;
            held_count_reg    <= '0;
            literals_left_reg <= '0;
            pad_pending_reg   <= 1'b0;
            column_reg        <= '0;
            row_index_reg     <= '0;
            finished_reg      <= 1'b0;
        end else if (s_accept) begin
            phase_reg         <= phase_next;
            held_count_reg    <= held_count_next;
            literals_left_reg <= literals_left_next;
            pad_pending_reg   <= pad_pending_next;
            column_reg        <= column_next;
            row_index_reg     <= row_index_next;
            finished_reg      <= finished_next;
        end
    end

    // Output register: load on accept, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg  <= m_data_next;
            m_flags_reg <= m_flags_next;
        end
    end

    // A result with no write carries an all-zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_flags_reg.write_valid) |-> (m_data_reg == '0))
        else $error("write-less result has a nonzero payload");

    // A new result only follows an accepted input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_accept))
        else $error("result appeared without an input transaction");

    // End of bitmap holds until a clearing byte arrives
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finished_reg && !(s_accept && in_first)) |=> finished_reg)
        else $error("finished flag dropped without a clear");

    // A literal byte in a live decode gives a one-byte write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !in_first && !cur_done && phase_reg == PH_LITERAL)
        |=> (m_flags_reg.write_valid && m_data_reg.write_length == 8'd1))
        else $error("literal byte did not produce a single-byte write");

endmodule : bmp_rle8_decoder_top

`default_nettype wire
